/* src/pipwh_pkg.sv */
// Package for the point-in-polygon-with-holes unit.
// Holds the default coordinate width and the register index codes.
// No dependencies.
package pipwh_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_QUERY_LON = 1'b0,
        REG_QUERY_LAT = 1'b1
    } cfg_reg_t;

endpackage

/* src/pipwh_edge.sv */
// Edge crossing unit: registers the two cross products of one edge test
// and compares them. Depends on pipwh_pkg for the default width.
module pipwh_edge #(
    parameter int CW = pipwh_pkg::COORD_WIDTH
) (
    input  logic               aclk,
    input  logic               load,
    input  logic               live_in,
    input  logic signed [CW:0] a_in,
    input  logic signed [CW:0] dy_in,
    input  logic signed [CW:0] c_in,
    input  logic signed [CW:0] d_in,
    output logic               cross_out
);

    localparam int PW = 2 * CW + 2;

    logic                   live_reg;
    logic                   dy_neg_reg;
    logic signed [PW-1:0]   p1_reg;
    logic signed [PW-1:0]   p2_reg;
    logic signed [PW-1:0]   p1_next;
    logic signed [PW-1:0]   p2_next;

    assign p1_next = PW'(a_in) * PW'(dy_in);
    assign p2_next = PW'(c_in) * PW'(d_in);

    always_ff @(posedge aclk) begin
        if (load) begin
            live_reg   <= live_in;
            dy_neg_reg <= dy_in[CW];
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
        end
    end

    // edge straddles the ray, so dy is never zero when live
    assign cross_out = live_reg && (dy_neg_reg ? (p2_reg < p1_reg) : (p1_reg < p2_reg));

endmodule

/* src/point_in_polygon_with_holes_unit.sv */
// Point-in-polygon-with-holes unit, top level.
// Depends on pipwh_pkg and pipwh_edge.
//
// Usage:
//   Write the query point through the cfg channel (index 0 longitude,
//   index 1 latitude) while the unit is idle. Then stream polygon vertices
//   on the s_ channel, one transfer per vertex, ring after ring; the first
//   ring is the exterior, later rings are holes. s_ring_end marks a ring's
//   last vertex, s_polygon_end the polygon's last vertex (and closes the
//   ring as well).
//   For each polygon end, one transfer on the m_ channel carries
//   m_inside_res: inside the exterior and in no hole. Other vertices give
//   no result.
//   m_valid rises after the polygon-end vertex transfer has passed the
//   operand register, the product register and the result register.
//   Throughput: one vertex per cycle while s_ready is high; both edge
//   tests of a vertex run in parallel through their own pair of multipliers.
//   Reset clears the query point to zero and starts a fresh polygon.
//   While a result waits on m_ready, vertices that give no result keep
//   flowing; only a second pending result stalls s_ready.
module point_in_polygon_with_holes_unit #(
    parameter int CW = pipwh_pkg::COORD_WIDTH
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [CW-1:0]                    s_vertex_lon,
    input  logic signed [CW-1:0]                    s_vertex_lat,
    input  logic                                    s_ring_end,
    input  logic                                    s_polygon_end,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_inside_res,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [pipwh_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic signed [CW-1:0]                    cfg_data
);

    logic signed [CW-1:0] qlon_reg, qlat_reg;
    logic signed [CW-1:0] first_lon_reg, first_lat_reg, prev_lon_reg, prev_lat_reg;
    logic at_start_reg, on_ext_reg, ext_hit_reg, hole_hit_reg, parity_reg;

    logic va_reg, rend_a_reg, pend_a_reg;
    logic vb_reg, rend_b_reg, pend_b_reg;
    logic m_valid_reg, m_inside_reg;

    logic accept, move_a, drain_b, ready_b, out_free;
    logic rend_in;
    logic signed [CW-1:0] first_lon_next, first_lat_next;

    logic signed [CW:0] x_ext, y_ext, qlon_ext, qlat_ext;
    logic signed [CW:0] fx_ext, fy_ext, px_ext, py_ext;
    logic signed [CW:0] e1_a_next, e1_dy_next, e1_c_next, e1_d_next;
    logic signed [CW:0] e2_a_next, e2_dy_next, e2_c_next, e2_d_next;
    logic signed [CW:0] e1_a_reg, e1_dy_reg, e1_c_reg, e1_d_reg;
    logic signed [CW:0] e2_a_reg, e2_dy_reg, e2_c_reg, e2_d_reg;
    logic e1_live_next, e2_live_next, e1_live_reg, e2_live_reg;
    logic cross1, cross2, parity_next, ext_next, hole_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qlon_reg <= '0;
            qlat_reg <= '0;
        end else if (cfg_valid) begin
            case (pipwh_pkg::cfg_reg_t'(cfg_index))
                pipwh_pkg::REG_QUERY_LON: qlon_reg <= cfg_data;
                pipwh_pkg::REG_QUERY_LAT: qlat_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // flow control
    assign out_free = !m_valid_reg || m_ready;
    assign drain_b  = vb_reg && (!pend_b_reg || out_free);
    assign ready_b  = !vb_reg || drain_b;
    assign move_a   = va_reg && ready_b;
    assign s_ready  = !va_reg || move_a;
    assign accept   = s_valid && s_ready;

    // operand stage
    assign rend_in        = s_ring_end || s_polygon_end;
    assign first_lon_next = at_start_reg ? s_vertex_lon : first_lon_reg;
    assign first_lat_next = at_start_reg ? s_vertex_lat : first_lat_reg;

    assign x_ext    = {s_vertex_lon[CW-1], s_vertex_lon};
    assign y_ext    = {s_vertex_lat[CW-1], s_vertex_lat};
    assign qlon_ext = {qlon_reg[CW-1], qlon_reg};
    assign qlat_ext = {qlat_reg[CW-1], qlat_reg};
    assign fx_ext   = {first_lon_next[CW-1], first_lon_next};
    assign fy_ext   = {first_lat_next[CW-1], first_lat_next};
    assign px_ext   = {prev_lon_reg[CW-1], prev_lon_reg};
    assign py_ext   = {prev_lat_reg[CW-1], prev_lat_reg};

    // edge from previous vertex to this one
    assign e1_a_next    = qlon_ext - x_ext;
    assign e1_dy_next   = py_ext - y_ext;
    assign e1_c_next    = px_ext - x_ext;
    assign e1_d_next    = qlat_ext - y_ext;
    assign e1_live_next = !at_start_reg
                          && ((s_vertex_lat > qlat_reg) != (prev_lat_reg > qlat_reg));

    // closing edge from this vertex back to the ring's first
    assign e2_a_next    = qlon_ext - fx_ext;
    assign e2_dy_next   = y_ext - fy_ext;
    assign e2_c_next    = x_ext - fx_ext;
    assign e2_d_next    = qlat_ext - fy_ext;
    assign e2_live_next = rend_in
                          && ((first_lat_next > qlat_reg) != (s_vertex_lat > qlat_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            at_start_reg <= 1'b1;
        end else if (accept) begin
            at_start_reg <= rend_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            first_lon_reg <= first_lon_next;
            first_lat_reg <= first_lat_next;
            prev_lon_reg  <= s_vertex_lon;
            prev_lat_reg  <= s_vertex_lat;
            e1_a_reg      <= e1_a_next;
            e1_dy_reg     <= e1_dy_next;
            e1_c_reg      <= e1_c_next;
            e1_d_reg      <= e1_d_next;
            e1_live_reg   <= e1_live_next;
            e2_a_reg      <= e2_a_next;
            e2_dy_reg     <= e2_dy_next;
            e2_c_reg      <= e2_c_next;
            e2_d_reg      <= e2_d_next;
            e2_live_reg   <= e2_live_next;
            rend_a_reg    <= rend_in;
            pend_a_reg    <= s_polygon_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
        end else if (accept) begin
            va_reg <= 1'b1;
        end else if (move_a) begin
            va_reg <= 1'b0;
        end
    end

    // product stage
    pipwh_edge #(.CW(CW)) u_edge_prev (
        .aclk      (aclk),
        .load      (move_a),
        .live_in   (e1_live_reg),
        .a_in      (e1_a_reg),
        .dy_in     (e1_dy_reg),
        .c_in      (e1_c_reg),
        .d_in      (e1_d_reg),
        .cross_out (cross1)
    );

    pipwh_edge #(.CW(CW)) u_edge_close (
        .aclk      (aclk),
        .load      (move_a),
        .live_in   (e2_live_reg),
        .a_in      (e2_a_reg),
        .dy_in     (e2_dy_reg),
        .c_in      (e2_c_reg),
        .d_in      (e2_d_reg),
        .cross_out (cross2)
    );

    always_ff @(posedge aclk) begin
        if (move_a) begin
            rend_b_reg <= rend_a_reg;
            pend_b_reg <= pend_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg <= 1'b0;
        end else if (move_a) begin
            vb_reg <= 1'b1;
        end else if (drain_b) begin
            vb_reg <= 1'b0;
        end
    end

    // parity and ring bookkeeping
    assign parity_next = parity_reg ^ cross1 ^ cross2;
    assign ext_next    = (rend_b_reg && on_ext_reg) ? parity_next : ext_hit_reg;
    assign hole_next   = hole_hit_reg || (rend_b_reg && !on_ext_reg && parity_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg   <= 1'b0;
            on_ext_reg   <= 1'b1;
            ext_hit_reg  <= 1'b0;
            hole_hit_reg <= 1'b0;
        end else if (drain_b) begin
            if (pend_b_reg) begin
                parity_reg   <= 1'b0;
                on_ext_reg   <= 1'b1;
                ext_hit_reg  <= 1'b0;
                hole_hit_reg <= 1'b0;
            end else if (rend_b_reg) begin
                parity_reg   <= 1'b0;
                on_ext_reg   <= 1'b0;
                ext_hit_reg  <= ext_next;
                hole_hit_reg <= hole_next;
            end else begin
                parity_reg   <= parity_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (drain_b && pend_b_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (drain_b && pend_b_reg) begin
            m_inside_reg <= ext_next && !hole_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;

`ifndef SYNTHESIS
    a_result_from_polygon_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(vb_reg && pend_b_reg))
        else $error("result raised without a polygon end");

    a_stall_only_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready && vb_reg && pend_b_reg))
        else $error("input stalled without a waiting result");

    a_polygon_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (drain_b && pend_b_reg) |=> (on_ext_reg && !ext_hit_reg && !hole_hit_reg && !parity_reg))
        else $error("polygon state not cleared after polygon end");
`endif

endmodule
